>>> design/svt_pkg.sv
// Shared types and codes for the sorted value table.
// No dependencies; used by the controller, datapath, top level and checker.
`timescale 1ns / 1ps

package svt_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_DN,
    S_SHIFT_UP,
    S_RESP
  } state_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_INC,
    IDX_DEC,
    IDX_COUNT
  } idx_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_CLEAR,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  // which neighbor of the next index the RAM reads
  typedef enum logic [1:0] {
    RD_SAME,
    RD_NEXT,
    RD_PREV
  } rd_sel_t;

  typedef struct packed {
    logic    load;
    idx_op_t idx_op;
    cnt_op_t cnt_op;
    rd_sel_t rd_sel;
    logic    pos_save;
    logic    wr_en;
    logic    wr_sel_value;
    logic    set_status;
    status_t status_code;
  } ctl_t;

  typedef struct packed {
    cmd_t cmd_q;
    logic full;
    logic empty;
    logic at_end;
    logic lt;
    logic eq;
    logic dn_done;
    logic up_done;
  } flags_t;

endpackage

>>> design/svt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module svt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/svt_dp.sv
// Datapath: entry RAM, walk index, stored count, saved position and status.
// Depends on svt_pkg and svt_ram.
`timescale 1ns / 1ps

module svt_dp #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         command,
  input  logic signed [31:0] value,
  input  svt_pkg::ctl_t      ctl,
  output svt_pkg::flags_t    flags,
  output logic [1:0]         status,
  output logic [4:0]         entry_count
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);

  svt_pkg::cmd_t      cmd_q;
  logic signed [31:0] value_q;
  logic [CW-1:0]      idx;
  logic [CW-1:0]      idx_next;
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic [CW-1:0]      pos;
  svt_pkg::status_t   status_q;
  logic [CW-1:0]      raddr_full;
  logic signed [31:0] rdata;
  logic [31:0]        wdata;

  always_comb begin
    case (ctl.idx_op)
      svt_pkg::IDX_ZERO:  idx_next = '0;
      svt_pkg::IDX_INC:   idx_next = idx + CW'(1);
      svt_pkg::IDX_DEC:   idx_next = idx - CW'(1);
      svt_pkg::IDX_COUNT: idx_next = count;
      default:            idx_next = idx;
    endcase
  end

  always_comb begin
    case (ctl.cnt_op)
      svt_pkg::CNT_CLEAR: count_next = '0;
      svt_pkg::CNT_INC:   count_next = count + CW'(1);
      svt_pkg::CNT_DEC:   count_next = count - CW'(1);
      default:            count_next = count;
    endcase
  end

  // read data arrives in the cycle after its address, so address from the next index
  always_comb begin
    case (ctl.rd_sel)
      svt_pkg::RD_NEXT: raddr_full = idx_next + CW'(1);
      svt_pkg::RD_PREV: raddr_full = idx_next - CW'(1);
      default:          raddr_full = idx_next;
    endcase
  end

  assign wdata = ctl.wr_sel_value ? value_q : rdata;

  svt_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.wr_en),
    .waddr (idx[AW-1:0]),
    .wdata (wdata),
    .raddr (raddr_full[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      idx      <= '0;
      status_q <= svt_pkg::ST_DONE;
    end else begin
      count <= count_next;
      idx   <= idx_next;
      if (ctl.set_status) begin
        status_q <= ctl.status_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q   <= svt_pkg::cmd_t'(command);
      value_q <= value;
    end
    if (ctl.pos_save) begin
      pos <= idx;
    end
  end

  assign flags.cmd_q   = cmd_q;
  assign flags.full    = (count == CW'(DEPTH));
  assign flags.empty   = (count == '0);
  assign flags.at_end  = (idx == count);
  assign flags.lt      = (rdata < value_q);
  assign flags.eq      = (rdata == value_q);
  assign flags.dn_done = (idx == pos);
  assign flags.up_done = ({1'b0, idx} + (CW + 1)'(1)) >= {1'b0, count};

  assign status      = status_q;
  assign entry_count = 5'(count);

endmodule

>>> design/svt_ctrl.sv
// Controller state machine: sequences scan, shift and answer per request.
// Depends on svt_pkg.
`timescale 1ns / 1ps

module svt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [1:0]      command,
  input  svt_pkg::flags_t flags,
  output svt_pkg::ctl_t   ctl,
  output logic            busy,
  output logic            done
);

  svt_pkg::state_t state;
  svt_pkg::state_t state_next;
  logic            stop;
  logic            found;

  assign stop  = flags.at_end || !flags.lt;
  assign found = !flags.at_end && flags.eq;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= svt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      svt_pkg::S_IDLE: begin
        if (start) begin
          case (svt_pkg::cmd_t'(command))
            svt_pkg::CMD_CLEAR:  state_next = svt_pkg::S_RESP;
            svt_pkg::CMD_INSERT: state_next = flags.full ? svt_pkg::S_RESP : svt_pkg::S_SCAN;
            default:             state_next = flags.empty ? svt_pkg::S_RESP : svt_pkg::S_SCAN;
          endcase
        end
      end
      svt_pkg::S_SCAN: begin
        if (stop) begin
          case (flags.cmd_q)
            svt_pkg::CMD_INSERT: state_next = svt_pkg::S_SHIFT_DN;
            svt_pkg::CMD_REMOVE: state_next = found ? svt_pkg::S_SHIFT_UP : svt_pkg::S_RESP;
            default:             state_next = svt_pkg::S_RESP;
          endcase
        end
      end
      svt_pkg::S_SHIFT_DN: if (flags.dn_done) state_next = svt_pkg::S_RESP;
      svt_pkg::S_SHIFT_UP: if (flags.up_done) state_next = svt_pkg::S_RESP;
      svt_pkg::S_RESP:     state_next = svt_pkg::S_IDLE;
      default:             state_next = svt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl              = '0;
    ctl.idx_op       = svt_pkg::IDX_HOLD;
    ctl.cnt_op       = svt_pkg::CNT_HOLD;
    ctl.status_code  = svt_pkg::ST_DONE;
    case (state_next)
      svt_pkg::S_SHIFT_UP: ctl.rd_sel = svt_pkg::RD_NEXT;
      svt_pkg::S_SHIFT_DN: ctl.rd_sel = svt_pkg::RD_PREV;
      default:             ctl.rd_sel = svt_pkg::RD_SAME;
    endcase
    case (state)
      svt_pkg::S_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          ctl.idx_op = svt_pkg::IDX_ZERO;
          case (svt_pkg::cmd_t'(command))
            svt_pkg::CMD_CLEAR: begin
              ctl.cnt_op      = svt_pkg::CNT_CLEAR;
              ctl.set_status  = 1'b1;
              ctl.status_code = svt_pkg::ST_DONE;
            end
            svt_pkg::CMD_INSERT: begin
              ctl.set_status  = flags.full;
              ctl.status_code = svt_pkg::ST_FULL;
            end
            default: begin
              ctl.set_status  = flags.empty;
              ctl.status_code = svt_pkg::ST_EMPTY;
            end
          endcase
        end
      end
      svt_pkg::S_SCAN: begin
        if (!stop) begin
          ctl.idx_op = svt_pkg::IDX_INC;
        end else begin
          ctl.pos_save    = 1'b1;
          ctl.set_status  = 1'b1;
          ctl.status_code = found ? svt_pkg::ST_DONE : svt_pkg::ST_NOT_FOUND;
          if (flags.cmd_q == svt_pkg::CMD_INSERT) begin
            ctl.idx_op      = svt_pkg::IDX_COUNT;
            ctl.status_code = svt_pkg::ST_DONE;
          end
        end
      end
      svt_pkg::S_SHIFT_DN: begin
        // move entries up one slot from the top, then drop the new value in
        ctl.wr_en = 1'b1;
        if (flags.dn_done) begin
          ctl.wr_sel_value = 1'b1;
          ctl.cnt_op       = svt_pkg::CNT_INC;
        end else begin
          ctl.idx_op = svt_pkg::IDX_DEC;
        end
      end
      svt_pkg::S_SHIFT_UP: begin
        if (flags.up_done) begin
          ctl.cnt_op = svt_pkg::CNT_DEC;
        end else begin
          ctl.wr_en  = 1'b1;
          ctl.idx_op = svt_pkg::IDX_INC;
        end
      end
      default: ;
    endcase
  end

  assign busy = (state != svt_pkg::S_IDLE);
  assign done = (state == svt_pkg::S_RESP);

endmodule

>>> design/sorted_value_table.sv
// Sorted value table: clear, full or empty cases answer straight from idle; otherwise a
// scan finds the position, then an insert or a found remove shifts the entries before the
// answer; the walk is one RAM read a cycle.
// busy stays high through the done cycle; the next request can be taken in the cycle after
// done. done cannot be held off by the receiver.
// Synchronous reset empties the table; entry contents are not cleared.
`timescale 1ns / 1ps

module sorted_value_table #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         command,
  input  logic signed [31:0] value,
  output logic               done,
  output logic [1:0]         status,
  output logic [4:0]         entry_count
);

  svt_pkg::ctl_t   ctl;
  svt_pkg::flags_t flags;

  svt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .flags   (flags),
    .ctl     (ctl),
    .busy    (busy),
    .done    (done)
  );

  svt_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .command     (command),
    .value       (value),
    .ctl         (ctl),
    .flags       (flags),
    .status      (status),
    .entry_count (entry_count)
  );

endmodule

>>> design/svt_checker.sv
// Port-level checks for the sorted value table, bound to the top level.
// Depends on svt_pkg and sorted_value_table.
`timescale 1ns / 1ps

module svt_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] command,
  input logic       done,
  input logic [1:0] status,
  input logic [4:0] entry_count
);

  // an accepted request holds off new ones
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted request");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done longer than one cycle");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("done while idle");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command == svt_pkg::CMD_CLEAR) |=>
      (done && status == svt_pkg::ST_DONE && entry_count == 5'd0))
    else $error("clear did not answer empty");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == svt_pkg::ST_EMPTY) |-> (entry_count == 5'd0))
    else $error("empty status with nonzero count");

endmodule

bind sorted_value_table svt_checker u_svt_checker (.*);
